// ----- src/ptid_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the per-track interval and delta block.
// No dependencies; every other file imports this package.
package ptid_pkg;

    localparam int TRACKS = 1024;
    localparam int TRK_W  = $clog2(TRACKS);

    // input transaction
    typedef struct packed {
        logic [9:0]         track_num;
        logic [62:0]        timestamp;
        logic signed [63:0] sample_value;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [31:0]        row_index;
        logic               has_previous;
        logic [31:0]        previous_row;
        logic signed [63:0] duration;
        logic signed [63:0] value_change;
    } t_out;

    // one entry of the per-track table
    typedef struct packed {
        logic        seen;
        logic [31:0] row;
        logic [62:0] stamp;
        logic [63:0] value;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic clear_en;
        logic capture;
        logic exec;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
    } t_sts;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// ----- src/ptid_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: table clearing pass, accept and execute steps.
// Depends on ptid_pkg.
module ptid_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ptid_pkg::t_sts i_sts,
    output ptid_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import ptid_pkg::*;

    t_state r_state;
    t_state n_state;

    // hold state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // decode next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.clear_en = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.exec     = 1'b0;
        o_busy         = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- src/ptid_dpath.sv -----
`timescale 1ns / 1ps
// Datapath: per-track table memory, row counter, duration and saturated delta.
// Depends on ptid_pkg.
module ptid_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptid_pkg::t_cmd i_cmd,
    input  ptid_pkg::t_in  i_item,
    output ptid_pkg::t_sts o_sts,
    output ptid_pkg::t_out o_result,
    output logic           o_result_valid
);
    import ptid_pkg::*;

    t_entry             r_mem [TRACKS];
    t_entry             r_rdata;
    t_in                r_item;
    logic [TRK_W-1:0]   r_clr_addr;
    logic [31:0]        r_row;
    t_out               r_out;
    logic               r_valid;

    logic [TRK_W-1:0]   w_rd_idx;
    logic [TRK_W-1:0]   w_wr_idx;
    t_entry             w_wentry;
    t_out               w_out;
    logic [63:0]        w_diff;
    logic               w_ovf;
    logic [63:0]        w_sat;

    assign w_rd_idx         = i_item.track_num[TRK_W-1:0];
    assign w_wr_idx         = r_item.track_num[TRK_W-1:0];
    assign o_sts.clear_done = (r_clr_addr == TRK_W'(TRACKS - 1));

    // saturating value change
    assign w_diff = r_item.sample_value - r_rdata.value;
    assign w_ovf  = (r_item.sample_value[63] ^ r_rdata.value[63])
                  & (w_diff[63] ^ r_item.sample_value[63]);
    assign w_sat  = r_item.sample_value[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};

    // build result and new table entry
    always_comb begin
        w_out.row_index    = r_row;
        w_out.has_previous = r_rdata.seen;
        if (r_rdata.seen) begin
            w_out.previous_row = r_rdata.row;
            w_out.duration     = {1'b0, r_item.timestamp} - {1'b0, r_rdata.stamp};
            w_out.value_change = w_ovf ? w_sat : w_diff;
        end else begin
            w_out.previous_row = '0;
            w_out.duration     = '0;
            w_out.value_change = '0;
        end
        w_wentry.seen  = 1'b1;
        w_wentry.row   = r_row;
        w_wentry.stamp = r_item.timestamp;
        w_wentry.value = r_item.sample_value;
    end

    // table write port: clearing pass or write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.exec) begin
            r_mem[w_wr_idx] <= w_wentry;
        end
    end

    // table read port and input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rdata <= r_mem[w_rd_idx];
            r_item  <= i_item;
        end
        if (i_cmd.exec) begin
            r_out <= w_out;
        end
    end

    // advance clear address, row counter and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_row      <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.exec) begin
                r_row <= r_row + 32'd1;
            end
            r_valid <= i_cmd.exec;
        end
    end

    assign o_result       = r_out;
    assign o_result_valid = r_valid;

endmodule

// ----- src/per_track_interval_and_delta.sv -----
`timescale 1ns / 1ps
// Per-track interval and delta unit, top level. Depends on ptid_pkg,
// ptid_ctrl and ptid_dpath.
// The result and its strobe are registered at the end of the execute step that
// follows the accepting edge. A new transaction is accepted only in idle, after the
// table's registered read and its write-back on the single table memory are done.
// Reset: a clearing pass zeroes all 1024 table entries; busy stays high meanwhile.
// The receiver cannot stall; each result is shown for one cycle.
module per_track_interval_and_delta (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ptid_pkg::t_in  i_item,
    output ptid_pkg::t_out o_result,
    output logic           o_result_valid
);
    import ptid_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequence clearing, accept and execute
    ptid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // table, counter and arithmetic
    ptid_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_item         (i_item),
        .o_sts          (w_sts),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule
